// ===== design/tfb_pkg.sv =====
// Shared types, constants and the CRC helper for the telemetry frame builder.
package tfb_pkg;

    // Default sizes handed to the top level
    localparam int MAX_DATA_DEF     = 1024;
    localparam int NUM_CHANNELS_DEF = 8;

    // Primary plus secondary header bytes ahead of the data field
    localparam int HDR_BYTES = 10;

    // Field widths fixed by the frame layout
    localparam int SCID_W  = 10;
    localparam int VC_W    = 3;
    localparam int FHP_W   = 11;
    localparam int LEN_W   = 11;
    localparam int POS_W   = 12;
    localparam int COUNT_W = 8;
    localparam int CFG_W   = SCID_W;

    // Request codes
    typedef enum logic [1:0] {
        ACT_PULL = 2'd0,
        ACT_DATA = 2'd1,
        ACT_IDLE = 2'd2
    } action_t;

    // Response status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NO_FRAME = 2'd2;

    // Configuration register indexes
    localparam logic REG_SCID = 1'b0;
    localparam logic REG_IDLE = 1'b1;

    // Frame constants
    localparam logic [FHP_W-1:0] IDLE_FHP      = 11'h7FE;
    localparam logic [4:0]       STATUS_FLAGS  = 5'b10011;
    localparam logic [7:0]       FILL_BYTE     = 8'hFF;
    localparam logic [15:0]      CRC_INIT      = 16'hFFFF;
    localparam logic [15:0]      CRC_POLY      = 16'h1021;
    localparam logic [VC_W-1:0]  IDLE_VC_RESET = 3'd7;

    typedef struct packed {
        logic [1:0]       action;
        logic [VC_W-1:0]  vcid;
        logic [FHP_W-1:0] first_header_pointer;
        logic [LEN_W-1:0] payload_len;
        logic [7:0]       data_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       data_used;
        logic       frame_end;
        logic [1:0] status;
    } rsp_t;

    // Bytewise CRC-16 update, MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== design/tfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/telemetry_frame_builder.sv =====
// Telemetry transfer frame builder: frame start and bytewise serializer with CRC-16.
// A request's response passes the read stage, then the output register.
// Throughput: one request per cycle while the response output is not stalled,
// set by the read-modify-write of the channel count memory.
// Reset clears all counters, the frame state and the output valid flag at once;
// the count memory is covered by per-channel valid bits, so no clearing pass runs.
module telemetry_frame_builder #(
    parameter int MAX_DATA     = tfb_pkg::MAX_DATA_DEF,
    parameter int NUM_CHANNELS = tfb_pkg::NUM_CHANNELS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  tfb_pkg::req_t        req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output tfb_pkg::rsp_t        rsp,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [tfb_pkg::CFG_W-1:0] cfg_data
);

    import tfb_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [POS_W-1:0] POS_DATA   = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(HDR_BYTES + MAX_DATA);
    localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(HDR_BYTES + MAX_DATA + 1);
    localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_DATA);

    // Configuration
    logic [SCID_W-1:0] scid_reg;
    logic [VC_W-1:0]   idle_vc_reg;

    // Channel read stage
    logic            s1_valid_reg;
    req_t            s1_item_reg;
    logic [VC_W-1:0] s1_ch_reg;

    // Frame state
    logic               frame_open_reg, frame_open_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]        header_reg, header_next;
    logic [15:0]        status_word_reg, status_word_next;
    logic [15:0]        counts_reg, counts_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic [15:0]        crc_reg, crc_next;
    logic [COUNT_W-1:0] master_reg, master_next;

    // Channel count memory support
    logic [NUM_CHANNELS-1:0] cnt_valid_reg;
    logic                    fwd_valid_reg;
    logic [CH_W-1:0]         fwd_ch_reg;
    logic [COUNT_W-1:0]      fwd_val_reg;
    logic                    ram_we;
    logic [COUNT_W-1:0]      ram_wdata;
    logic [COUNT_W-1:0]      ram_rdata;

    // Output register
    logic rsp_valid_reg;
    rsp_t rsp_reg, rsp_next;

    logic            req_accept;
    logic            advance;
    logic [VC_W-1:0] req_ch;
    logic [CH_W-1:0] ch_idx;
    logic            ch_ok;
    logic [COUNT_W-1:0] cnt_cur;
    logic [POS_W-1:0]   pos_off;
    logic [7:0]         pull_byte;
    logic               pull_used;

    // Handshake
    assign advance    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !advance;
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    // Resolve the channel of a start request
    assign req_ch = (req.action == ACT_IDLE) ? idle_vc_reg : req.vcid;
    assign ch_idx = s1_ch_reg[CH_W-1:0];
    assign ch_ok  = {29'd0, s1_ch_reg} < 32'(NUM_CHANNELS);

    tfb_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (NUM_CHANNELS),
        .AW    (CH_W)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_idx),
        .wdata (ram_wdata),
        .re    (req_accept),
        .raddr (req_ch[CH_W-1:0]),
        .rdata (ram_rdata)
    );

    // Current channel count: last write wins, unwritten entries read zero
    always_comb
    begin
        if (fwd_valid_reg && (fwd_ch_reg == ch_idx))
            cnt_cur = fwd_val_reg;
        else if (cnt_valid_reg[ch_idx])
            cnt_cur = ram_rdata;
        else
            cnt_cur = '0;
    end

    // Select the byte at the current frame position
    assign pos_off = pos_reg - POS_DATA;
    always_comb
    begin
        pull_used = 1'b0;
        if (pos_reg == POS_W'(0))
            pull_byte = header_reg[15:8];
        else if (pos_reg == POS_W'(1))
            pull_byte = header_reg[7:0];
        else if (pos_reg == POS_W'(2))
            pull_byte = counts_reg[15:8];
        else if (pos_reg == POS_W'(3))
            pull_byte = counts_reg[7:0];
        else if (pos_reg == POS_W'(4))
            pull_byte = status_word_reg[15:8];
        else if (pos_reg == POS_W'(5))
            pull_byte = status_word_reg[7:0];
        else if (pos_reg < POS_DATA)
            pull_byte = 8'h00;
        else if (pos_reg < POS_CRC_HI)
        begin
            if (pos_off < {1'b0, fill_reg})
            begin
                pull_byte = s1_item_reg.data_byte;
                pull_used = 1'b1;
            end
            else
                pull_byte = FILL_BYTE;
        end
        else if (pos_reg == POS_CRC_HI)
            pull_byte = crc_reg[15:8];
        else
            pull_byte = crc_reg[7:0];
    end

    // Process the request in the read stage
    always_comb
    begin
        rsp_next         = '0;
        frame_open_next  = frame_open_reg;
        pos_next         = pos_reg;
        header_next      = header_reg;
        status_word_next = status_word_reg;
        counts_next      = counts_reg;
        fill_next        = fill_reg;
        crc_next         = crc_reg;
        master_next      = master_reg;
        ram_we           = 1'b0;
        ram_wdata        = cnt_cur + COUNT_W'(1);
        if (advance)
        begin
            case (s1_item_reg.action)
                ACT_DATA, ACT_IDLE:
                begin
                    if (!ch_ok || ((s1_item_reg.action == ACT_DATA) &&
                                   (s1_item_reg.payload_len > LEN_MAX)))
                        rsp_next.status = ST_TOO_LONG;
                    else
                    begin
                        header_next = {2'b00, scid_reg, s1_ch_reg, 1'b0};
                        counts_next = {master_reg, cnt_cur};
                        master_next = master_reg + COUNT_W'(1);
                        ram_we      = 1'b1;
                        pos_next    = '0;
                        crc_next    = CRC_INIT;
                        frame_open_next = 1'b1;
                        if (s1_item_reg.action == ACT_IDLE)
                        begin
                            status_word_next = {STATUS_FLAGS, IDLE_FHP};
                            fill_next        = '0;
                        end
                        else
                        begin
                            status_word_next = {STATUS_FLAGS,
                                                s1_item_reg.first_header_pointer};
                            fill_next        = s1_item_reg.payload_len;
                        end
                    end
                end
                default:
                begin
                    if (!frame_open_reg)
                        rsp_next.status = ST_NO_FRAME;
                    else
                    begin
                        rsp_next.out_byte   = pull_byte;
                        rsp_next.byte_valid = 1'b1;
                        rsp_next.data_used  = pull_used;
                        if (pos_reg < POS_CRC_HI)
                            crc_next = crc_update(crc_reg, pull_byte);
                        if (pos_reg > POS_CRC_HI)
                        begin
                            rsp_next.frame_end = 1'b1;
                            frame_open_next    = 1'b0;
                            pos_next           = '0;
                        end
                        else
                            pos_next = pos_reg + POS_W'(1);
                    end
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scid_reg    <= '0;
            idle_vc_reg <= IDLE_VC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCID: scid_reg    <= cfg_data;
                REG_IDLE: idle_vc_reg <= cfg_data[VC_W-1:0];
                default:  scid_reg    <= scid_reg;
            endcase
        end
    end

    // Read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (req_accept)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // Read stage payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_item_reg <= req;
            s1_ch_reg   <= req_ch;
        end
    end

    // Frame state, counters and count forwarding
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            pos_reg         <= '0;
            header_reg      <= '0;
            status_word_reg <= '0;
            counts_reg      <= '0;
            fill_reg        <= '0;
            crc_reg         <= CRC_INIT;
            master_reg      <= '0;
            cnt_valid_reg   <= '0;
            fwd_valid_reg   <= 1'b0;
            fwd_ch_reg      <= '0;
            fwd_val_reg     <= '0;
        end
        else
        begin
            frame_open_reg  <= frame_open_next;
            pos_reg         <= pos_next;
            header_reg      <= header_next;
            status_word_reg <= status_word_next;
            counts_reg      <= counts_next;
            fill_reg        <= fill_next;
            crc_reg         <= crc_next;
            master_reg      <= master_next;
            if (ram_we)
            begin
                cnt_valid_reg[ch_idx] <= 1'b1;
                fwd_valid_reg         <= 1'b1;
                fwd_ch_reg            <= ch_idx;
                fwd_val_reg           <= ram_wdata;
            end
        end
    end

    // Output register: load on advance, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

`ifndef SYNTHESIS
    a_pos_closed: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> (pos_reg == '0))
        else $error("frame position nonzero with no frame open");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CRC_LO)
        else $error("frame position beyond last CRC byte");

    a_ram_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ch_ok && advance))
        else $error("channel count written for an invalid channel");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && rsp_next.frame_end) |=> (!frame_open_reg && (crc_reg == $past(crc_reg))))
        else $error("frame end left the frame open or changed the CRC");

    a_used_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.data_used) |-> (rsp_reg.byte_valid && !rsp_reg.frame_end))
        else $error("data byte consumed outside the data field");
`endif

endmodule
